>>> src/swt_pkg.sv
package swt_pkg;

   localparam int TimeWidth           = 32;
   localparam int PeriodWidth         = 16;
   localparam int PidWidth            = 4;
   localparam int MaxWakes            = 16;
   localparam int ProcessCountDefault = 16;

   localparam logic [PeriodWidth-1:0] PeriodResetValue = PeriodWidth'(10);

   typedef enum logic [0:0] {
      OP_TICK  = 1'b0,
      OP_SLEEP = 1'b1
   } operation_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick_start;
      logic div_start;
      logic wake_write;
      logic scan_run;
      logic flush_run;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_sleep;
      logic pid_in_range;
      logic div_done;
      logic scan_drained;
      logic flush_done;
   } ctrl_status_type;

endpackage

>>> src/swt_ram.sv
module swt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/swt_divider.sv
module swt_divider
   import swt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [TimeWidth-1:0]   dividend,
   input  logic [PeriodWidth-1:0] divisor,
   output logic                   done,
   output logic [PeriodWidth-1:0] remainder
);

   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   localparam int StepWidth = $clog2(TimeWidth);
   localparam logic [StepWidth-1:0] LastStep = StepWidth'(TimeWidth - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [TimeWidth-1:0]   shift_ff, shift_in;
   logic [PeriodWidth-1:0] rem_ff, rem_in;
   logic [PeriodWidth-1:0] divisor_ff, divisor_in;
   logic [PeriodWidth:0]   trial;
   logic [PeriodWidth:0]   diff;

   always_comb begin
      trial      = {rem_ff, shift_ff[TimeWidth-1]};
      diff       = trial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[TimeWidth-2:0], 1'b0};
         rem_in   = diff[PeriodWidth] ? trial[PeriodWidth-1:0] : diff[PeriodWidth-1:0];
         step_in  = step_ff + StepWidth'(1);
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> src/swt_datapath.sv
module swt_datapath
   import swt_pkg::*;
#(
   parameter int PROCESS_COUNT = ProcessCountDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status,
   input  logic                   req_operation,
   input  logic [PidWidth-1:0]    req_process_id,
   input  logic [TimeWidth-1:0]   req_sleep_ms,
   input  logic                   csr_write_enable,
   input  logic [PeriodWidth-1:0] csr_write_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [PidWidth-1:0]    rsp_wake_process,
   output logic [TimeWidth-1:0]   rsp_time_now_ms,
   output logic                   rsp_last_wake
);

   localparam int IdxWidth     = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
   localparam int CntWidth     = $clog2(PROCESS_COUNT + 1);
   localparam int WakeCntWidth = $clog2(MaxWakes + 1);

   logic [PeriodWidth-1:0]   period_ff, period_in;
   logic [TimeWidth-1:0]     time_ff, time_in;
   logic [TimeWidth-1:0]     ms_ff, ms_in;
   logic [IdxWidth-1:0]      pid_ff, pid_in;
   logic [PROCESS_COUNT-1:0] valid_ff, valid_in;

   logic [CntWidth-1:0]      idx_ff, idx_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [IdxWidth-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [WakeCntWidth-1:0]  count_ff, count_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [IdxWidth-1:0]      pend_idx_ff, pend_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PidWidth-1:0]      rsp_proc_ff, rsp_proc_in;
   logic [TimeWidth-1:0]     rsp_time_ff, rsp_time_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     div_done;
   logic [PeriodWidth-1:0]   div_rem;
   logic [TimeWidth-1:0]     rounded;
   logic [TimeWidth-1:0]     wake_data;
   logic [TimeWidth-1:0]     rd_data;
   logic [TimeWidth-1:0]     wake_value;
   logic                     rd_en;
   logic                     issue_ok;
   logic                     match;
   logic                     out_free;
   logic                     stall;

   swt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (req_sleep_ms),
      .divisor   (period_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   swt_ram #(
      .WIDTH (TimeWidth),
      .DEPTH (PROCESS_COUNT)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (cmd.wake_write),
      .wr_addr (pid_ff),
      .wr_data (wake_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IdxWidth-1:0]),
      .rd_data (rd_data)
   );

   // A zero period is out of range; every sleep then rounds to zero.
   assign rounded   = (period_ff == '0) ? '0 : ms_ff - TimeWidth'(div_rem);
   assign wake_data = time_ff + rounded;

   // Entries never written read as zero.
   assign wake_value = valid_ff[cmp_idx_ff] ? rd_data : '0;
   assign issue_ok   = (idx_ff < CntWidth'(PROCESS_COUNT)) &&
                       (count_ff < WakeCntWidth'(MaxWakes));
   assign match      = cmp_valid_ff && (count_ff < WakeCntWidth'(MaxWakes)) &&
                       (wake_value == time_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stall      = match && pend_valid_ff && !out_free;
   assign rd_en      = cmd.scan_run && issue_ok && !stall;

   always_comb begin
      period_in     = csr_write_enable ? csr_write_data : period_ff;
      time_in       = time_ff;
      ms_in         = ms_ff;
      pid_in        = pid_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_proc_in   = rsp_proc_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.div_start) begin
         ms_in  = req_sleep_ms;
         pid_in = IdxWidth'(req_process_id);
      end
      if (cmd.wake_write) begin
         valid_in[pid_ff] = 1'b1;
      end
      if (cmd.tick_start) begin
         time_in       = time_ff + TimeWidth'(period_ff);
         idx_in        = '0;
         cmp_valid_in  = 1'b0;
         count_in      = '0;
         pend_valid_in = 1'b0;
      end

      // The newest match is held back until the next one, or the end of
      // the scan, shows whether it is the last of the tick.
      if (cmd.scan_run && !stall) begin
         cmp_valid_in = issue_ok;
         if (issue_ok) begin
            cmp_idx_in = idx_ff[IdxWidth-1:0];
            idx_in     = idx_ff + CntWidth'(1);
         end
         if (match) begin
            count_in      = count_ff + WakeCntWidth'(1);
            pend_valid_in = 1'b1;
            pend_idx_in   = cmp_idx_ff;
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_proc_in  = PidWidth'(pend_idx_ff);
               rsp_time_in  = time_ff;
               rsp_last_in  = 1'b0;
            end
         end
      end

      if (cmd.flush_run && pend_valid_ff && out_free) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_proc_in   = PidWidth'(pend_idx_ff);
         rsp_time_in   = time_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PeriodResetValue;
         time_ff       <= '0;
         valid_ff      <= '0;
         idx_ff        <= '0;
         cmp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         time_ff       <= time_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_ff       <= ms_in;
      pid_ff      <= pid_in;
      cmp_idx_ff  <= cmp_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_proc_ff <= rsp_proc_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.is_sleep     = (req_operation == OP_SLEEP);
   assign status.pid_in_range = (32'(req_process_id) < 32'(PROCESS_COUNT));
   assign status.div_done     = div_done;
   assign status.scan_drained = !issue_ok && !cmp_valid_ff;
   assign status.flush_done   = !pend_valid_ff || out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wake_process = rsp_proc_ff;
   assign rsp_time_now_ms  = rsp_time_ff;
   assign rsp_last_wake    = rsp_last_ff;

endmodule

>>> src/swt_controller.sv
module swt_controller
   import swt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_WRITE  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd.tick_start = accept && !status.is_sleep;
      cmd.div_start  = accept && status.is_sleep && status.pid_in_range;
      cmd.wake_write = (state_ff == ST_WRITE);
      cmd.scan_run   = (state_ff == ST_SCAN);
      cmd.flush_run  = (state_ff == ST_FLUSH);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.tick_start) begin
               state_in = ST_SCAN;
            end else if (cmd.div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_drained) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> src/sleep_wake_timer_table_unit.sv
// Multi-channel wakeup timer. The block keeps a 32-bit millisecond clock and
// one wake time per process. A sleep transfer sets that process's wake time
// to now plus the requested duration rounded down to a whole number of tick
// periods; it returns nothing, and a process index of PROCESS_COUNT or more
// is ignored. A tick transfer advances the clock by the period last written
// through csr_write_data and returns one transfer per process whose wake time
// equals the new time, in index order, at most sixteen, with rsp_last_wake
// set on the final one; a tick with no match returns nothing. One item is
// worked on at a time. A sleep occupies the block from its transfer until
// the next item can be taken: first the bit-serial remainder divider runs,
// then the controller sees the divider finish, then the wake table is
// written. A tick occupies it while the wake table RAM is scanned, read
// one entry per cycle except while the result side holds rsp_ready low
// with a result waiting, and its final result is handed on. The result
// register lets the next item be taken while the final result of a tick
// still waits. Wake entries that were never written read as zero through
// per-entry valid flags, so no clearing pass follows reset. The tick
// period resets to 10 ms and may only be written while the block is idle.
module sleep_wake_timer_table_unit
   import swt_pkg::*;
#(
   parameter int PROCESS_COUNT = ProcessCountDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [PidWidth-1:0]    req_process_id,
   input  logic [TimeWidth-1:0]   req_sleep_ms,
   input  logic                   csr_write_enable,
   input  logic [PeriodWidth-1:0] csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PidWidth-1:0]    rsp_wake_process,
   output logic [TimeWidth-1:0]   rsp_time_now_ms,
   output logic                   rsp_last_wake
);

   // The controller sequences each item; the datapath holds the clock, the
   // wake table, the divider and the result register.
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   swt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swt_datapath #(
      .PROCESS_COUNT (PROCESS_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_process_id   (req_process_id),
      .req_sleep_ms     (req_sleep_ms),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_wake_process (rsp_wake_process),
      .rsp_time_now_ms  (rsp_time_now_ms),
      .rsp_last_wake    (rsp_last_wake)
   );

endmodule

>>> src/swt_checker.sv
module swt_checker
   import swt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [PidWidth-1:0]    rsp_wake_process,
   input logic [TimeWidth-1:0]   rsp_time_now_ms,
   input logic                   rsp_last_wake
);

   // A waiting result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wake_process) &&
         $stable(rsp_time_now_ms) && $stable(rsp_last_wake))
      else $error("stalled result changed before its transfer");

   // A tick keeps the block busy while the wake table is scanned.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_TICK) |=> !req_ready)
      else $error("input taken during a tick scan");

   // A sleep never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_SLEEP) && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a sleep transfer");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sleep_wake_timer_table_unit swt_checker u_checker (.*);
